// File: sv/dtt_pkg.sv
// dtt_pkg: opcodes, status codes and the command record shared by the
// deadline timer table modules. Depends on nothing.
package dtt_pkg;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_CANCEL  = 3'd1;
   localparam logic [2:0] OP_REFRESH = 3'd2;
   localparam logic [2:0] OP_RESET   = 3'd3;
   localparam logic [2:0] OP_EXPIRE  = 3'd4;
   localparam logic [2:0] OP_QUERY   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INACTIVE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   localparam logic [31:0] WINDOW_RESET = 32'd3600000;
   localparam logic [63:0] NO_TIMER     = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  timer_id;
      logic [31:0] interval_ms;
      logic        recurring;
      logic        restart_now;
      logic [63:0] now_ms;
      logic        id_ok;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

// File: sv/deadline_timer_table.sv
// deadline_timer_table: top level joining the command queue front end and
// the slot scanning back end. Depends on dtt_pkg, dtt_front and dtt_back.
//
// Usage: requests enter on req_* (valid/ready), each carrying an opcode and
// the current time. Results leave on rsp_* (valid/ready); every request gives
// one result, expire gives one per due timer, and rsp_last marks the final
// one. csr_* writes the rollover window and is always ready; it is to be
// written only while the block is idle, which the block does not enforce.
// Cancel, a full add, expire on an empty table and unknown opcodes answer
// without a scan; refresh and a reset that changes nothing read their slot
// first. Add, query, an expire with nothing due and a reset that changes
// the timer scan all slots at one slot per cycle on a single comparator.
// Expire scans once to mark due timers and once more per expired timer.
// A two entry queue takes new requests while the back end works or waits.
// Reset clears all slots, the previous time and the pending notify, and sets
// the window to 3600000 ms. While rsp_ready is low the result is held and the
// back end stalls; requests still fill the queue until it is full.
module deadline_timer_table #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_timer_id,
   input  logic [31:0] req_interval_ms,
   input  logic        req_recurring,
   input  logic        req_restart_now,
   input  logic [63:0] req_now_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_timer_id_out,
   output logic        rsp_expired_valid,
   output logic [63:0] rsp_next_delay_ms,
   output logic        rsp_front_notify,
   output logic        rsp_has_timer,
   output logic        rsp_last
);
   import dtt_pkg::*;

   queue_head_type head;
   logic           pop;

   dtt_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_timer_id    (req_timer_id),
      .req_interval_ms (req_interval_ms),
      .req_recurring   (req_recurring),
      .req_restart_now (req_restart_now),
      .req_now_ms      (req_now_ms),
      .head            (head),
      .pop             (pop)
   );

   dtt_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_timer_id_out  (rsp_timer_id_out),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_next_delay_ms (rsp_next_delay_ms),
      .rsp_front_notify  (rsp_front_notify),
      .rsp_has_timer     (rsp_has_timer),
      .rsp_last          (rsp_last)
   );

endmodule

// File: sv/dtt_front.sv
// dtt_front: request intake, slot range check and a two entry command queue.
// Depends on dtt_pkg.
module dtt_front #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_opcode,
   input  logic [3:0]             req_timer_id,
   input  logic [31:0]            req_interval_ms,
   input  logic                   req_recurring,
   input  logic                   req_restart_now,
   input  logic [63:0]            req_now_ms,
   output dtt_pkg::queue_head_type head,
   input  logic                   pop
);
   import dtt_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   cmd_type    cmd_in;
   logic       push;
   logic       do_pop;

   always_comb begin
      cmd_in.opcode      = req_opcode;
      cmd_in.timer_id    = req_timer_id;
      cmd_in.interval_ms = req_interval_ms;
      cmd_in.recurring   = req_recurring;
      cmd_in.restart_now = req_restart_now;
      cmd_in.now_ms      = req_now_ms;
      cmd_in.id_ok       = ({28'd0, req_timer_id} < 32'(NUM_TIMERS));
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign do_pop     = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// File: sv/dtt_back.sv
// dtt_back: timer slot storage and the sequencer that executes commands by
// scanning slots one per cycle, plus the result register. Depends on dtt_pkg.
module dtt_back #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dtt_pkg::queue_head_type head,
   output logic                    pop,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [31:0]             csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [3:0]              rsp_timer_id_out,
   output logic                    rsp_expired_valid,
   output logic [63:0]             rsp_next_delay_ms,
   output logic                    rsp_front_notify,
   output logic                    rsp_has_timer,
   output logic                    rsp_last
);
   import dtt_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_TIMERS);

   typedef enum logic [2:0] {S_IDLE, S_READ, S_RESET2, S_SCAN, S_WAIT} state_type;
   typedef enum logic [1:0] {M_FRONT, M_QUERY, M_DUE, M_EMIT} mode_type;

   logic [63:0] dl_mem_ff [NUM_TIMERS];
   logic [31:0] pd_mem_ff [NUM_TIMERS];
   logic        rp_mem_ff [NUM_TIMERS];
   logic [63:0] dl_rd_ff;
   logic [31:0] pd_rd_ff;
   logic        rp_rd_ff;

   state_type             state_ff;
   state_type             after_ff;
   mode_type              mode_ff;
   cmd_type               cmd_ff;
   logic [NUM_TIMERS-1:0] active_ff;
   logic [NUM_TIMERS-1:0] due_ff;
   logic [63:0]           prev_ff;
   logic                  notify_ff;
   logic [31:0]           window_ff;
   logic                  roll_ff;
   logic                  ht_ff;
   logic [IDX_W-1:0]      slot_ff;
   logic [63:0]           start_ff;
   logic [CNT_W-1:0]      addr_ff;
   logic                  proc_v_ff;
   logic [IDX_W-1:0]      proc_idx_ff;
   logic                  best_v_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [63:0]           best_dl_ff;
   logic [31:0]           best_pd_ff;
   logic                  best_rp_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [3:0]            rsp_id_ff;
   logic                  rsp_ev_ff;
   logic [63:0]           rsp_nd_ff;
   logic                  rsp_fn_ff;
   logic                  rsp_ht_ff;
   logic                  rsp_last_ff;

   logic [IDX_W-1:0]      head_idx;
   logic [IDX_W-1:0]      cmd_idx;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      free_idx;
   logic                  free_found;
   logic [NUM_TIMERS-1:0] act_clr;
   logic [NUM_TIMERS-1:0] due_rest;
   logic [IDX_W+3:0]      head_ext;
   logic [IDX_W+3:0]      cmd_ext;
   logic [IDX_W+3:0]      free_ext;
   logic [IDX_W+3:0]      slot_ext;
   logic [IDX_W+3:0]      best_ext;
   logic [63:0]           delay;
   logic                  roll;
   logic                  scan_done;
   logic                  due_now;
   logic                  masked;

   assign head_ext = {{IDX_W{1'b0}}, head.cmd.timer_id};
   assign cmd_ext  = {{IDX_W{1'b0}}, cmd_ff.timer_id};
   assign head_idx = head_ext[IDX_W-1:0];
   assign cmd_idx  = cmd_ext[IDX_W-1:0];
   assign free_ext = {4'd0, free_idx};
   assign slot_ext = {4'd0, slot_ff};
   assign best_ext = {4'd0, best_idx_ff};

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
      act_clr           = active_ff;
      act_clr[head_idx] = 1'b0;
      due_rest              = due_ff;
      due_rest[best_idx_ff] = 1'b0;
   end

   assign delay     = (cmd_ff.now_ms >= best_dl_ff) ? 64'd0 : best_dl_ff - cmd_ff.now_ms;
   assign roll      = (head.cmd.now_ms < prev_ff) &&
                      ((prev_ff - head.cmd.now_ms) > {32'd0, window_ff});
   assign scan_done = (addr_ff == CNT_END) && !proc_v_ff;
   assign due_now   = active_ff[proc_idx_ff] && (roll_ff || (dl_rd_ff <= cmd_ff.now_ms));
   assign masked    = (mode_ff == M_EMIT) ? due_ff[proc_idx_ff] : active_ff[proc_idx_ff];
   assign rd_addr   = (state_ff == S_SCAN) ? addr_ff[IDX_W-1:0] : head_idx;
   assign pop       = (state_ff == S_IDLE) && head.valid;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      dl_rd_ff <= dl_mem_ff[rd_addr];
      pd_rd_ff <= pd_mem_ff[rd_addr];
      rp_rd_ff <= rp_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         after_ff     <= S_IDLE;
         active_ff    <= '0;
         prev_ff      <= 64'd0;
         notify_ff    <= 1'b0;
         window_ff    <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
         proc_v_ff    <= 1'b0;
         best_v_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            window_ff <= csr_wdata;
         end
         case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  cmd_ff        <= head.cmd;
                  rsp_status_ff <= ST_OK;
                  rsp_id_ff     <= head.cmd.timer_id;
                  rsp_ev_ff     <= 1'b0;
                  rsp_nd_ff     <= 64'd0;
                  rsp_fn_ff     <= 1'b0;
                  rsp_last_ff   <= 1'b1;
                  rsp_ht_ff     <= |active_ff;
                  after_ff      <= S_IDLE;
                  addr_ff       <= '0;
                  proc_v_ff     <= 1'b0;
                  best_v_ff     <= 1'b0;
                  case (head.cmd.opcode)
                     OP_ADD: begin
                        if (!free_found) begin
                           rsp_status_ff <= ST_FULL;
                           rsp_id_ff     <= 4'd0;
                           rsp_valid_ff  <= 1'b1;
                           state_ff      <= S_WAIT;
                        end else begin
                           dl_mem_ff[free_idx] <= head.cmd.now_ms +
                                                  {32'd0, head.cmd.interval_ms};
                           pd_mem_ff[free_idx] <= head.cmd.interval_ms;
                           rp_mem_ff[free_idx] <= head.cmd.recurring;
                           active_ff[free_idx] <= 1'b1;
                           slot_ff             <= free_idx;
                           rsp_id_ff           <= free_ext[3:0];
                           mode_ff             <= M_FRONT;
                           state_ff            <= S_SCAN;
                        end
                     end
                     OP_CANCEL: begin
                        if (head.cmd.id_ok && active_ff[head_idx]) begin
                           active_ff <= act_clr;
                           rsp_ht_ff <= |act_clr;
                        end else begin
                           rsp_status_ff <= ST_INACTIVE;
                        end
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_WAIT;
                     end
                     OP_REFRESH: begin
                        if (head.cmd.id_ok && active_ff[head_idx]) begin
                           state_ff <= S_READ;
                        end else begin
                           rsp_status_ff <= ST_INACTIVE;
                           rsp_valid_ff  <= 1'b1;
                           state_ff      <= S_WAIT;
                        end
                     end
                     OP_RESET: begin
                        if (head.cmd.id_ok) begin
                           state_ff <= S_READ;
                        end else begin
                           rsp_status_ff <= ST_INACTIVE;
                           rsp_valid_ff  <= 1'b1;
                           state_ff      <= S_WAIT;
                        end
                     end
                     OP_EXPIRE: begin
                        rsp_id_ff <= 4'd0;
                        if (!(|active_ff)) begin
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= S_WAIT;
                        end else begin
                           roll_ff  <= roll;
                           prev_ff  <= head.cmd.now_ms;
                           ht_ff    <= 1'b0;
                           due_ff   <= '0;
                           mode_ff  <= M_DUE;
                           state_ff <= S_SCAN;
                        end
                     end
                     OP_QUERY: begin
                        rsp_id_ff <= 4'd0;
                        notify_ff <= 1'b0;
                        mode_ff   <= M_QUERY;
                        state_ff  <= S_SCAN;
                     end
                     default: begin
                        rsp_id_ff    <= 4'd0;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_WAIT;
                     end
                  endcase
               end
            end
            S_READ: begin
               if (cmd_ff.opcode == OP_REFRESH) begin
                  dl_mem_ff[cmd_idx] <= cmd_ff.now_ms + {32'd0, pd_rd_ff};
                  rsp_valid_ff       <= 1'b1;
                  state_ff           <= S_WAIT;
               end else if ((cmd_ff.interval_ms == pd_rd_ff) && !cmd_ff.restart_now) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_WAIT;
               end else if (!active_ff[cmd_idx]) begin
                  rsp_status_ff <= ST_INACTIVE;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_WAIT;
               end else begin
                  start_ff <= cmd_ff.restart_now ? cmd_ff.now_ms :
                              dl_rd_ff - {32'd0, pd_rd_ff};
                  state_ff <= S_RESET2;
               end
            end
            S_RESET2: begin
               pd_mem_ff[cmd_idx] <= cmd_ff.interval_ms;
               dl_mem_ff[cmd_idx] <= start_ff + {32'd0, cmd_ff.interval_ms};
               slot_ff            <= cmd_idx;
               mode_ff            <= M_FRONT;
               state_ff           <= S_SCAN;
            end
            S_SCAN: begin
               proc_v_ff   <= (addr_ff != CNT_END);
               proc_idx_ff <= addr_ff[IDX_W-1:0];
               if (addr_ff != CNT_END) begin
                  addr_ff <= addr_ff + 1'b1;
               end
               if (proc_v_ff) begin
                  if (mode_ff == M_DUE) begin
                     due_ff[proc_idx_ff] <= due_now;
                     if (active_ff[proc_idx_ff] && !(due_now && !rp_rd_ff)) begin
                        ht_ff <= 1'b1;
                     end
                  end else if (masked && (!best_v_ff || (dl_rd_ff < best_dl_ff))) begin
                     best_v_ff   <= 1'b1;
                     best_idx_ff <= proc_idx_ff;
                     best_dl_ff  <= dl_rd_ff;
                     best_pd_ff  <= pd_rd_ff;
                     best_rp_ff  <= rp_rd_ff;
                  end
               end
               if (scan_done) begin
                  addr_ff   <= '0;
                  best_v_ff <= 1'b0;
                  case (mode_ff)
                     M_FRONT: begin
                        rsp_id_ff <= slot_ext[3:0];
                        rsp_ht_ff <= 1'b1;
                        if (best_v_ff && (best_idx_ff == slot_ff) && !notify_ff) begin
                           rsp_fn_ff <= 1'b1;
                           notify_ff <= 1'b1;
                        end
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_WAIT;
                     end
                     M_QUERY: begin
                        rsp_nd_ff    <= best_v_ff ? delay : NO_TIMER;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_WAIT;
                     end
                     M_DUE: begin
                        if (due_ff == '0) begin
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= S_WAIT;
                        end else begin
                           rsp_ht_ff <= ht_ff;
                           mode_ff   <= M_EMIT;
                        end
                     end
                     default: begin
                        due_ff <= due_rest;
                        if (best_rp_ff) begin
                           dl_mem_ff[best_idx_ff] <= cmd_ff.now_ms + {32'd0, best_pd_ff};
                        end else begin
                           active_ff[best_idx_ff] <= 1'b0;
                        end
                        rsp_id_ff    <= best_ext[3:0];
                        rsp_ev_ff    <= 1'b1;
                        rsp_ht_ff    <= ht_ff;
                        rsp_last_ff  <= (due_rest == '0);
                        after_ff     <= (due_rest == '0) ? S_IDLE : S_SCAN;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_WAIT;
                     end
                  endcase
               end
            end
            S_WAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= after_ff;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_timer_id_out  = rsp_id_ff;
   assign rsp_expired_valid = rsp_ev_ff;
   assign rsp_next_delay_ms = rsp_nd_ff;
   assign rsp_front_notify  = rsp_fn_ff;
   assign rsp_has_timer     = rsp_ht_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// File: bench/tb_deadline_timer_table.sv
// tb_deadline_timer_table: self-checking bench for the deadline timer table.
// A directed table and a random run are checked against an in-bench
// predictor. Depends on dtt_pkg and deadline_timer_table.
module tb_deadline_timer_table;
   timeunit 1ns;
   timeprecision 1ps;
   import dtt_pkg::*;

   localparam int SLOTS = 16;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [2:0]  op;
      logic [3:0]  id;
      logic [31:0] ival;
      logic        rec;
      logic        fnow;
      logic [63:0] now;
   } request_type;

   typedef struct {
      logic [1:0]  status;
      logic [3:0]  id;
      logic        expv;
      logic [63:0] delay;
      logic        notify;
      logic        has;
      logic        last;
   } outcome_type;

   typedef struct {
      request_type rq;
      bit          typed;
      logic [1:0]  status;
      logic [3:0]  id;
      logic [63:0] delay;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, csr_valid = 0, rsp_ready = 0;
   logic [2:0] req_opcode = 0;
   logic [3:0] req_timer_id = 0;
   logic [31:0] req_interval_ms = 0, csr_wdata = 0;
   logic req_recurring = 0, req_restart_now = 0;
   logic [63:0] req_now_ms = 0;
   logic req_ready, csr_ready, rsp_valid;
   logic [1:0] rsp_status;
   logic [3:0] rsp_timer_id_out;
   logic rsp_expired_valid, rsp_front_notify, rsp_has_timer, rsp_last;
   logic [63:0] rsp_next_delay_ms;

   deadline_timer_table dut (.*);

   initial forever #4 clock = ~clock;

   // predictor state
   logic [63:0] t_deadline [SLOTS];
   logic [31:0] t_period [SLOTS];
   bit t_repeat [SLOTS], t_active [SLOTS], t_written [SLOTS];
   logic [63:0] t_prev_time;
   bit t_notify;
   logic [31:0] t_window;

   outcome_type pending_results[$];
   int errors = 0;
   bit calm = 0;
   int hold_token = 0;
   logic [63:0] cur_now = 0;

   function automatic bit orders_first(int a, int b);
      if (t_deadline[a] != t_deadline[b]) return t_deadline[a] < t_deadline[b];
      return a < b;
   endfunction

   function automatic int earliest_slot();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (t_active[i] && (best < 0 || orders_first(i, best))) best = i;
      return best;
   endfunction

   function automatic bit front_check(int s);
      if (earliest_slot() == s && !t_notify) begin
         t_notify = 1;
         return 1;
      end
      return 0;
   endfunction

   function automatic outcome_type plain(logic [1:0] st, logic [3:0] id);
      outcome_type o;
      o = '{status: st, id: id, expv: 0, delay: 0, notify: 0, has: 0, last: 0};
      return o;
   endfunction

   // works out the results of one accepted request and queues them
   task automatic predict_timers(input request_type r, output outcome_type first_out);
      outcome_type outs[$];
      outcome_type o;
      int s, best;
      bit roll, anyact;
      bit due [SLOTS];
      logic [63:0] start;
      s = -1;
      case (r.op)
         OP_ADD: begin
            for (int i = SLOTS - 1; i >= 0; i--) if (!t_active[i]) s = i;
            if (s < 0) outs = {outs, plain(ST_FULL, 0)};
            else begin
               t_deadline[s] = r.now + 64'(r.ival);
               t_period[s] = r.ival;
               t_repeat[s] = r.rec;
               t_active[s] = 1;
               t_written[s] = 1;
               o = plain(ST_OK, 4'(s));
               o.notify = front_check(s);
               outs = {outs, o};
            end
         end
         OP_CANCEL: begin
            if (t_active[r.id]) begin
               t_active[r.id] = 0;
               outs = {outs, plain(ST_OK, r.id)};
            end else outs = {outs, plain(ST_INACTIVE, r.id)};
         end
         OP_REFRESH: begin
            if (t_active[r.id]) begin
               t_deadline[r.id] = r.now + 64'(t_period[r.id]);
               outs = {outs, plain(ST_OK, r.id)};
            end else outs = {outs, plain(ST_INACTIVE, r.id)};
         end
         OP_RESET: begin
            if (r.ival == t_period[r.id] && !r.fnow) outs = {outs, plain(ST_OK, r.id)};
            else if (!t_active[r.id]) outs = {outs, plain(ST_INACTIVE, r.id)};
            else begin
               start = r.fnow ? r.now : t_deadline[r.id] - 64'(t_period[r.id]);
               t_period[r.id] = r.ival;
               t_deadline[r.id] = start + 64'(r.ival);
               o = plain(ST_OK, r.id);
               o.notify = front_check(r.id);
               outs = {outs, o};
            end
         end
         OP_EXPIRE: begin
            best = earliest_slot();
            if (best < 0) outs = {outs, plain(ST_OK, 0)};
            else begin
               roll = r.now < t_prev_time && (t_prev_time - r.now) > 64'(t_window);
               t_prev_time = r.now;
               if (!roll && t_deadline[best] > r.now) outs = {outs, plain(ST_OK, 0)};
               else begin
                  for (int i = 0; i < SLOTS; i++)
                     due[i] = t_active[i] && (roll || t_deadline[i] <= r.now);
                  forever begin
                     best = -1;
                     for (int i = 0; i < SLOTS; i++)
                        if (due[i] && (best < 0 || orders_first(i, best))) best = i;
                     if (best < 0) break;
                     due[best] = 0;
                     o = plain(ST_OK, 4'(best));
                     o.expv = 1;
                     outs = {outs, o};
                     if (t_repeat[best]) t_deadline[best] = r.now + 64'(t_period[best]);
                     else t_active[best] = 0;
                  end
                  if (outs.size() == 0) outs = {outs, plain(ST_OK, 0)};
               end
            end
         end
         OP_QUERY: begin
            best = earliest_slot();
            t_notify = 0;
            o = plain(ST_OK, 0);
            o.delay = NO_TIMER;
            if (best >= 0)
               o.delay = (r.now >= t_deadline[best]) ? 64'd0 : t_deadline[best] - r.now;
            outs = {outs, o};
         end
         default: outs = {outs, plain(ST_OK, 0)};
      endcase
      anyact = 0;
      for (int i = 0; i < SLOTS; i++) anyact |= t_active[i];
      foreach (outs[k]) begin
         outs[k].has = anyact;
         outs[k].last = (k == outs.size() - 1);
         pending_results = {pending_results, outs[k]};
      end
      first_out = outs[0];
   endtask

   task automatic send_request(input request_type r, output outcome_type first_out);
      if (!calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= r.op;
      req_timer_id <= r.id;
      req_interval_ms <= r.ival;
      req_recurring <= r.rec;
      req_restart_now <= r.fnow;
      req_now_ms <= r.now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_timers(r, first_out);
   endtask

   task automatic drain_results();
      req_valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_window(input logic [31:0] value);
      drain_results();
      csr_valid <= 1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      t_window = value;
   endtask

   function automatic request_type random_request();
      request_type r;
      int pick, w;
      r.id = 4'($urandom_range(0, 15));
      r.ival = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($urandom_range(0, 150));
      r.rec = 1'($urandom);
      r.fnow = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70) cur_now += 64'($urandom_range(0, 60));
      else if (pick < 80) cur_now -= 64'($urandom_range(0, 30));
      else if (pick < 88) cur_now -= {32'd0, 32'($urandom)};
      else if (pick < 95) cur_now = {32'($urandom), 32'($urandom)};
      else cur_now = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 100));
      r.now = cur_now;
      w = $urandom_range(0, 99);
      if (w < 30) r.op = OP_ADD;
      else if (w < 42) r.op = OP_CANCEL;
      else if (w < 54) r.op = OP_REFRESH;
      else if (w < 66) r.op = OP_RESET;
      else if (w < 88) r.op = OP_EXPIRE;
      else if (w < 98) r.op = OP_QUERY;
      else r.op = 3'($urandom_range(6, 7));
      if (r.op == OP_RESET) begin
         if (!t_written[r.id] || $urandom_range(0, 3) == 0)
            for (int i = 0; i < SLOTS; i++) if (t_written[i] && $urandom_range(0, 2) == 0) r.id = 4'(i);
         if (!t_written[r.id]) r.op = OP_QUERY;
         else if ($urandom_range(0, 4) == 0) begin
            r.ival = t_period[r.id];
            r.fnow = 0;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : receiver
      int hold_left, seen;
      if (hold_token != seen) begin
         seen = hold_token;
         hold_left = 250;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 36);
   end

   always @(posedge clock) begin : result_check
      outcome_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: expected no result, actual status %0d id %0d", $realtime,
                     rsp_status, rsp_timer_id_out);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status || rsp_timer_id_out !== e.id ||
                rsp_expired_valid !== e.expv || rsp_next_delay_ms !== e.delay ||
                rsp_front_notify !== e.notify || rsp_has_timer !== e.has ||
                rsp_last !== e.last) begin
               $display("%0t: expected st %0d id %0d exp %0b dly %h ntf %0b has %0b last %0b",
                        $realtime, e.status, e.id, e.expv, e.delay, e.notify, e.has, e.last);
               $display("%0t: actual   st %0d id %0d exp %0b dly %h ntf %0b has %0b last %0b",
                        $realtime, rsp_status, rsp_timer_id_out, rsp_expired_valid,
                        rsp_next_delay_ms, rsp_front_notify, rsp_has_timer, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("deadline_timer_table verification failed");
         $finish;
      end
   end

   row_type directed [$];

   function automatic row_type mk(logic [2:0] op, logic [3:0] id, logic [31:0] ival,
                                  logic rec, logic fnow, logic [63:0] now, bit typed = 0,
                                  logic [1:0] st = ST_OK, logic [3:0] rid = 0,
                                  logic [63:0] dly = 0);
      row_type r;
      r.rq = '{op: op, id: id, ival: ival, rec: rec, fnow: fnow, now: now};
      r.typed = typed;
      r.status = st;
      r.id = rid;
      r.delay = dly;
      return r;
   endfunction

   initial begin
      outcome_type got;
      logic [31:0] windows [4];
      for (int i = 0; i < SLOTS; i++) begin
         t_active[i] = 0;
         t_written[i] = 0;
         t_period[i] = 0;
         t_deadline[i] = 0;
         t_repeat[i] = 0;
      end
      t_prev_time = 0;
      t_notify = 0;
      t_window = WINDOW_RESET;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed = '{
         mk(OP_QUERY, 0, 0, 0, 0, 0, 1, ST_OK, 0, NO_TIMER),
         mk(OP_EXPIRE, 0, 0, 0, 0, 100, 1, ST_OK, 0, 0),
         mk(OP_CANCEL, 3, 0, 0, 0, 100, 1, ST_INACTIVE, 3, 0),
         mk(OP_REFRESH, 15, 0, 0, 0, 100, 1, ST_INACTIVE, 15, 0),
         mk(OP_ADD, 0, 0, 0, 0, 10, 1, ST_OK, 0, 0),
         mk(OP_ADD, 0, 32'hFFFF_FFFF, 1, 0, 10, 1, ST_OK, 1, 0),
         mk(OP_ADD, 0, 50, 1, 1, 64'hFFFF_FFFF_FFFF_FFF0, 1, ST_OK, 2, 0),
         mk(OP_QUERY, 0, 0, 0, 0, 20),
         mk(OP_RESET, 1, 32'hFFFF_FFFF, 1, 0, 20, 1, ST_OK, 1, 0),
         mk(OP_RESET, 1, 5, 0, 1, 20),
         mk(OP_REFRESH, 2, 0, 0, 0, 30),
         mk(OP_EXPIRE, 0, 0, 0, 0, 1000),
         mk(3'd6, 9, 1, 1, 1, 5, 1, ST_OK, 0, 0),
         mk(3'd7, 15, 32'hFFFF_FFFF, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 0, 0),
         mk(OP_CANCEL, 1, 0, 0, 0, 1000),
         mk(OP_RESET, 0, 0, 0, 0, 1000, 1, ST_OK, 0, 0),
         mk(OP_QUERY, 0, 0, 0, 0, 1000),
         mk(OP_ADD, 0, 100, 1, 0, 10_000_000),
         mk(OP_ADD, 0, 7, 0, 0, 10_000_000),
         mk(OP_EXPIRE, 0, 0, 0, 0, 10_000_000),
         mk(OP_EXPIRE, 0, 0, 0, 0, 5),
         mk(OP_QUERY, 0, 0, 0, 0, 5)
      };
      foreach (directed[i]) begin
         send_request(directed[i].rq, got);
         if (directed[i].typed && (got.status !== directed[i].status ||
             got.id !== directed[i].id || got.delay !== directed[i].delay)) begin
            $display("%0t: row %0d expected st %0d id %0d dly %h, actual st %0d id %0d dly %h",
                     $realtime, i, directed[i].status, directed[i].id, directed[i].delay,
                     got.status, got.id, got.delay);
            errors++;
         end
      end

      windows = '{32'd0, 32'hFFFF_FFFF, 32'($urandom_range(1, 1000)), WINDOW_RESET};
      cur_now = 5;
      for (int phase = 0; phase < 4; phase++) begin
         write_window(windows[phase]);
         calm = (phase == 1);
         for (int n = 0; n < 95; n++) begin
            if (phase == 2 && n == 10) begin
               calm = 1;
               hold_token++;
            end
            if (phase == 2 && n == 40) calm = 0;
            if (phase == 3 && n == 45) drain_results();
            send_request(random_request(), got);
         end
      end
      calm = 0;
      drain_results();
      if (errors == 0) $display("deadline_timer_table verification clean");
      else $display("deadline_timer_table verification failed");
      $finish;
   end
endmodule
